/* design/tssc_pkg.sv */
`timescale 1ns / 1ps
package tssc_pkg;
    localparam int unsigned CFG_IDX_BITS = 3;
    localparam int unsigned CFG_DATA_BITS = 20;
    localparam logic [CFG_IDX_BITS-1:0] REG_ALPHA_SHARED = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ALPHA_CH5 = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ALPHA_CH7 = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_ALPHA_SPEED = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPEED_NUM = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPEED_TIMEOUT = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] REG_CLICK_SHORT = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] REG_CLICK_LONG = 3'd7;

    localparam logic [1:0] CLICK_NONE = 2'd0;
    localparam logic [1:0] CLICK_SINGLE = 2'd1;
    localparam logic [1:0] CLICK_LONG = 2'd2;

    localparam logic [6:0] HOLD_MAX = 7'd100;
    localparam logic [10:0] TALLY_MAX = 11'd2047;
    localparam int unsigned SPEED_BITS = 20;
    localparam int unsigned SPEED_AVG_BITS = 36;
endpackage

/* design/tssc_ema_lane.sv */
`timescale 1ns / 1ps
// One exponential average, A' = ((1 - w) * A + w * (x << 16)) >> 16.
// Computed as A + ((w * ((x << 16) - A)) >> 16) with a floor, split into a
// multiply step and an add step.
module tssc_ema_lane
    import tssc_pkg::*;
#(
    parameter int unsigned XBITS = 12
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 clear,
    input  logic [XBITS-1:0]     x,
    input  logic [15:0]          w,
    output logic [XBITS+15:0]    avg
);
    localparam int unsigned AW = XBITS + 16;

    logic [AW-1:0]      avg_reg;
    logic [AW:0]        diff;
    logic [AW+16:0]     prod_reg;
    logic               busy_reg;
    logic [AW+16:0]     sum;

    // Signed difference, one extra bit.
    assign diff = {1'b0, x, 16'd0} - {1'b0, avg_reg};
    assign sum = {{17{1'b0}}, avg_reg} + {{16{prod_reg[AW+16]}}, prod_reg[AW+16:16]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_reg <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= start;
            if (busy_reg)
                avg_reg <= sum[AW-1:0];
            else if (clear)
                avg_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            prod_reg <= $signed(diff) * $signed({1'b0, w});
    end

    assign avg = avg_reg;
endmodule

/* design/tssc_divider.sv */
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle. A zero divisor gives 0.
module tssc_divider
    import tssc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [SPEED_BITS-1:0] num,
    input  logic [15:0]           den,
    output logic                  done,
    output logic [SPEED_BITS-1:0] quot
);
    logic [SPEED_BITS-1:0] q_reg;
    logic [16:0]           rem_reg;
    logic [15:0]           den_reg;
    logic [4:0]            cnt_reg;
    logic                  run_reg;
    logic                  done_reg;
    logic [16:0]           trial;
    logic [17:0]           sub;

    assign trial = {rem_reg[15:0], q_reg[SPEED_BITS-1]};
    assign sub = {1'b0, trial} - {2'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 5'(SPEED_BITS - 1);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0)
                begin
                    run_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (run_reg)
        begin
            if (!sub[17])
            begin
                rem_reg <= sub[16:0];
                q_reg <= {q_reg[SPEED_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                q_reg <= {q_reg[SPEED_BITS-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = (den_reg == 16'd0) ? '0 : q_reg;
endmodule

/* design/tick_sensor_smoother_click_detect.sv */
`timescale 1ns / 1ps
// Flow: an accepted input beat starts the channel lanes and the 20-step serial divider for the
// speed value; the quotient then feeds the speed average, and a pulse timeout clears that average
// before the result beat is shown. A new tick is taken only after the sink has taken the result
// beat; the divider sets this pace, and the channel lanes finish inside it.
// Reset: rst_n is asynchronous and active low; all averages, counters and the
// frame window clear and the configuration registers take their default values.
module tick_sensor_smoother_click_detect
    import tssc_pkg::*;
#(
    parameter int unsigned CHANNELS = 8,
    parameter int unsigned SAMPLE_BITS = 12,
    parameter int unsigned FPS_WINDOW = 100
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [11:0]                sample_ch0,
    input  logic [11:0]                sample_ch1,
    input  logic [11:0]                sample_ch2,
    input  logic [11:0]                sample_ch3,
    input  logic [11:0]                sample_ch4,
    input  logic [11:0]                sample_ch5,
    input  logic [11:0]                sample_ch6,
    input  logic [11:0]                sample_ch7,
    input  logic [15:0]                speed_period,
    input  logic                       speed_pulse,
    input  logic                       switch_level,
    input  logic [3:0]                 frames_done,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [11:0]                smooth_ch0,
    output logic [11:0]                smooth_ch1,
    output logic [11:0]                smooth_ch2,
    output logic [11:0]                smooth_ch3,
    output logic [11:0]                smooth_ch4,
    output logic [11:0]                smooth_ch5,
    output logic [11:0]                smooth_ch6,
    output logic [11:0]                smooth_ch7,
    output logic [19:0]                speed_value,
    output logic [10:0]                frames_per_second,
    output logic [1:0]                 click_event
);
    localparam int unsigned NL = (CHANNELS < 8) ? CHANNELS : 8;
    localparam int unsigned AW = SAMPLE_BITS + 16;

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_SPEED, ST_OUT} state_t;

    // Configuration registers.
    logic [15:0] alpha_shared_reg, alpha_ch5_reg, alpha_ch7_reg, alpha_speed_reg;
    logic [19:0] speed_num_reg;
    logic [6:0]  speed_timeout_reg, click_short_reg, click_long_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_shared_reg <= 16'd32768;
            alpha_ch5_reg <= 16'd655;
            alpha_ch7_reg <= 16'd7;
            alpha_speed_reg <= 16'd655;
            speed_num_reg <= 20'd704372;
            speed_timeout_reg <= 7'd100;
            click_short_reg <= 7'd10;
            click_long_reg <= 7'd50;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ALPHA_SHARED:  alpha_shared_reg <= cfg_data[15:0];
                REG_ALPHA_CH5:     alpha_ch5_reg <= cfg_data[15:0];
                REG_ALPHA_CH7:     alpha_ch7_reg <= cfg_data[15:0];
                REG_ALPHA_SPEED:   alpha_speed_reg <= cfg_data[15:0];
                REG_SPEED_NUM:     speed_num_reg <= cfg_data;
                REG_SPEED_TIMEOUT: speed_timeout_reg <= cfg_data[6:0];
                REG_CLICK_SHORT:   click_short_reg <= cfg_data[6:0];
                REG_CLICK_LONG:    click_long_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    state_t state_reg;
    logic   accept;
    logic   div_done;
    logic [SPEED_BITS-1:0] div_q;
    logic   speed_start_reg;
    logic   speed_clear_reg;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept = in_valid && in_ready;

    // Channel lanes: each runs one average while the divider works.
    logic [11:0] samp [8];
    assign samp[0] = sample_ch0;
    assign samp[1] = sample_ch1;
    assign samp[2] = sample_ch2;
    assign samp[3] = sample_ch3;
    assign samp[4] = sample_ch4;
    assign samp[5] = sample_ch5;
    assign samp[6] = sample_ch6;
    assign samp[7] = sample_ch7;

    logic [11:0] smooth [8];

    for (genvar i = 0; i < 8; i++)
    begin : g_lane
        if (i < NL)
        begin : g_on
            logic [AW-1:0] avg;
            logic [SAMPLE_BITS-1:0] xs;
            assign xs = SAMPLE_BITS'(samp[i]);
            tssc_ema_lane #(.XBITS(SAMPLE_BITS)) u_lane (
                .clk(clk), .rst_n(rst_n), .start(accept), .clear(1'b0),
                .x(xs),
                .w((i == 5) ? alpha_ch5_reg : ((i == 7) ? alpha_ch7_reg : alpha_shared_reg)),
                .avg(avg)
            );
            assign smooth[i] = 12'(avg >> 16);
        end
        else
        begin : g_off
            assign smooth[i] = '0;
        end
    end

    // Speed path: divider, then one average lane.
    tssc_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(accept),
        .num(speed_num_reg), .den(speed_period),
        .done(div_done), .quot(div_q)
    );

    logic [SPEED_AVG_BITS-1:0] speed_avg;
    tssc_ema_lane #(.XBITS(SPEED_BITS)) u_speed (
        .clk(clk), .rst_n(rst_n), .start(speed_start_reg), .clear(speed_clear_reg),
        .x(div_q), .w(alpha_speed_reg), .avg(speed_avg)
    );

    // Timer and switch state, updated on acceptance.
    logic [6:0]  idle_reg, hold_reg, win_reg;
    logic [10:0] tally_reg, fps_reg;
    logic [1:0]  click_reg;
    logic        timeout_reg;
    logic [6:0]  hold_new, win_new;
    logic [7:0]  idle_inc;
    logic [11:0] tally_sum;
    logic [10:0] tally_new;

    always_comb
    begin
        // One bit wider so an idle count of 127 plus one still exceeds any timeout.
        idle_inc = {1'b0, (speed_pulse ? 7'd0 : idle_reg)} + 8'd1;
        hold_new = switch_level ? 7'd0 : ((hold_reg >= HOLD_MAX) ? HOLD_MAX : hold_reg + 7'd1);
        win_new = win_reg + 7'd1;
        tally_sum = {1'b0, tally_reg} + {8'd0, frames_done};
        tally_new = tally_sum[11] ? TALLY_MAX : tally_sum[10:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idle_reg <= '0;
            hold_reg <= '0;
            win_reg <= '0;
            tally_reg <= '0;
            fps_reg <= '0;
            click_reg <= CLICK_NONE;
            timeout_reg <= 1'b0;
            speed_start_reg <= 1'b0;
            speed_clear_reg <= 1'b0;
        end
        else
        begin
            speed_start_reg <= 1'b0;
            speed_clear_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= ST_DIV;
                        if (idle_inc > {1'b0, speed_timeout_reg})
                        begin
                            idle_reg <= speed_timeout_reg;
                            timeout_reg <= 1'b1;
                        end
                        else
                        begin
                            idle_reg <= idle_inc[6:0];
                            timeout_reg <= 1'b0;
                        end
                        hold_reg <= hold_new;
                        if (hold_new == click_short_reg)
                            click_reg <= CLICK_SINGLE;
                        else if (hold_new >= click_long_reg)
                            click_reg <= CLICK_LONG;
                        else
                            click_reg <= CLICK_NONE;
                        if (32'(win_new) >= FPS_WINDOW)
                        begin
                            fps_reg <= tally_new;
                            tally_reg <= '0;
                            win_reg <= '0;
                        end
                        else
                        begin
                            tally_reg <= tally_new;
                            win_reg <= win_new;
                        end
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        speed_start_reg <= 1'b1;
                        state_reg <= ST_SPEED;
                    end
                end
                ST_SPEED:
                begin
                    // Average lands this cycle; a timeout wipes it next cycle.
                    if (!speed_start_reg)
                    begin
                        speed_clear_reg <= timeout_reg;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_ready && !speed_clear_reg)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid = (state_reg == ST_OUT) && !speed_clear_reg;
    assign smooth_ch0 = smooth[0];
    assign smooth_ch1 = smooth[1];
    assign smooth_ch2 = smooth[2];
    assign smooth_ch3 = smooth[3];
    assign smooth_ch4 = smooth[4];
    assign smooth_ch5 = smooth[5];
    assign smooth_ch6 = smooth[6];
    assign smooth_ch7 = smooth[7];
    assign speed_value = speed_avg[35:16];
    assign frames_per_second = fps_reg;
    assign click_event = click_reg;

    // The block never takes a beat while a result is pending.
    assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
        else $error("input taken while result pending");
    // A timed-out speed reads as zero when shown.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && timeout_reg) |-> (speed_value == '0))
        else $error("speed not cleared after timeout");
    // The hold counter never exceeds its ceiling.
    assert property (@(posedge clk) disable iff (!rst_n) hold_reg <= HOLD_MAX)
        else $error("hold count over limit");
endmodule

/* tb/tssc_checker.sv */
`timescale 1ns / 1ps
// Watches the input and result sides of the tick smoother, predicts each result beat and compares.
module tssc_checker
    import tssc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [11:0] sample_ch0,
    input  logic [11:0] sample_ch1,
    input  logic [11:0] sample_ch2,
    input  logic [11:0] sample_ch3,
    input  logic [11:0] sample_ch4,
    input  logic [11:0] sample_ch5,
    input  logic [11:0] sample_ch6,
    input  logic [11:0] sample_ch7,
    input  logic [15:0] speed_period,
    input  logic        speed_pulse,
    input  logic        switch_level,
    input  logic [3:0]  frames_done,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [11:0] smooth_ch0,
    input  logic [11:0] smooth_ch1,
    input  logic [11:0] smooth_ch2,
    input  logic [11:0] smooth_ch3,
    input  logic [11:0] smooth_ch4,
    input  logic [11:0] smooth_ch5,
    input  logic [11:0] smooth_ch6,
    input  logic [11:0] smooth_ch7,
    input  logic [19:0] speed_value,
    input  logic [10:0] frames_per_second,
    input  logic [1:0]  click_event,
    output int          error_count,
    output int          pending_count
);
    typedef struct packed {
        logic [7:0][11:0] smooth;
        logic [19:0]      speed;
        logic [10:0]      fps;
        logic [1:0]       click;
    } tick_result_t;

    tick_result_t tick_results_due[$];

    logic [27:0] ch_avg [8];
    logic [35:0] spd_avg;
    logic [6:0]  idle_ticks, hold_ticks, win_ticks;
    logic [10:0] tally, fps_last;
    logic [15:0] w_shared, w_ch5, w_ch7, w_speed;
    logic [19:0] numerator;
    logic [6:0]  timeout, short_cnt, long_cnt;

    function automatic logic [63:0] smooth_q16(logic [63:0] avg, logic [63:0] x,
                                               logic [15:0] w);
        logic [63:0] keep;
        keep = 64'd65536 - w;
        return (keep * avg + 64'(w) * (x << 16)) >> 16;
    endfunction

    task automatic predict_tick(input logic [7:0][11:0] samples);
        tick_result_t r;
        logic [11:0] sum;
        logic [19:0] speed_now;
        logic [7:0]  idle;
        logic [15:0] w;
        sum = 12'(tally) + 12'(frames_done);
        tally = (sum > 12'(TALLY_MAX)) ? TALLY_MAX : sum[10:0];
        win_ticks = win_ticks + 7'd1;
        if (win_ticks >= 7'd100)
        begin
            fps_last = tally;
            tally = '0;
            win_ticks = '0;
        end
        for (int i = 0; i < 8; i++)
        begin
            w = (i == 5) ? w_ch5 : (i == 7) ? w_ch7 : w_shared;
            ch_avg[i] = 28'(smooth_q16(64'(ch_avg[i]), 64'(samples[i]), w));
            r.smooth[i] = ch_avg[i][27:16];
        end
        speed_now = (speed_period == 0) ? 20'd0 : 20'(numerator / speed_period);
        spd_avg = 36'(smooth_q16(64'(spd_avg), 64'(speed_now), w_speed));
        idle = speed_pulse ? 8'd1 : 8'(idle_ticks) + 8'd1;
        if (idle > 8'(timeout))
        begin
            idle = 8'(timeout);
            spd_avg = '0;
        end
        idle_ticks = idle[6:0];
        r.speed = spd_avg[35:16];
        if (!switch_level)
            hold_ticks = (hold_ticks >= HOLD_MAX) ? HOLD_MAX : hold_ticks + 7'd1;
        else
            hold_ticks = '0;
        if (hold_ticks == short_cnt)
            r.click = CLICK_SINGLE;
        else if (hold_ticks >= long_cnt)
            r.click = CLICK_LONG;
        else
            r.click = CLICK_NONE;
        r.fps = fps_last;
        tick_results_due.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tick_result_t got, want;
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                ch_avg[i] = '0;
            spd_avg = '0;
            idle_ticks = '0; hold_ticks = '0; win_ticks = '0;
            tally = '0; fps_last = '0;
            w_shared = 16'd32768; w_ch5 = 16'd655; w_ch7 = 16'd7; w_speed = 16'd655;
            numerator = 20'd704372; timeout = 7'd100;
            short_cnt = 7'd10; long_cnt = 7'd50;
            tick_results_due.delete();
            error_count = 0;
            pending_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ALPHA_SHARED:  w_shared = cfg_data[15:0];
                    REG_ALPHA_CH5:     w_ch5 = cfg_data[15:0];
                    REG_ALPHA_CH7:     w_ch7 = cfg_data[15:0];
                    REG_ALPHA_SPEED:   w_speed = cfg_data[15:0];
                    REG_SPEED_NUM:     numerator = cfg_data;
                    REG_SPEED_TIMEOUT: timeout = cfg_data[6:0];
                    REG_CLICK_SHORT:   short_cnt = cfg_data[6:0];
                    REG_CLICK_LONG:    long_cnt = cfg_data[6:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                got.smooth = {smooth_ch7, smooth_ch6, smooth_ch5, smooth_ch4,
                              smooth_ch3, smooth_ch2, smooth_ch1, smooth_ch0};
                got.speed = speed_value;
                got.fps = frames_per_second;
                got.click = click_event;
                if (tick_results_due.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected: %h", $time, got);
                    error_count++;
                end
                else
                begin
                    want = tick_results_due.pop_front();
                    for (int i = 0; i < 8; i++)
                        if (got.smooth[i] !== want.smooth[i])
                        begin
                            $display("%0t: smooth_ch%0d expected %0d actual %0d", $time, i,
                                     want.smooth[i], got.smooth[i]);
                            error_count++;
                        end
                    if (got.speed !== want.speed)
                    begin
                        $display("%0t: speed_value expected %0d actual %0d", $time,
                                 want.speed, got.speed);
                        error_count++;
                    end
                    if (got.fps !== want.fps)
                    begin
                        $display("%0t: frames_per_second expected %0d actual %0d", $time,
                                 want.fps, got.fps);
                        error_count++;
                    end
                    if (got.click !== want.click)
                    begin
                        $display("%0t: click_event expected %0d actual %0d", $time,
                                 want.click, got.click);
                        error_count++;
                    end
                end
            end
            // Prediction comes after the pop so a same-edge beat never matches itself.
            if (in_valid && in_ready)
                predict_tick({sample_ch7, sample_ch6, sample_ch5, sample_ch4,
                              sample_ch3, sample_ch2, sample_ch1, sample_ch0});
            pending_count = tick_results_due.size();
        end
    end
endmodule

/* tb/tb_tick_sensor_smoother_click_detect.sv */
`timescale 1ns / 1ps
// Stimulus and verdict for the tick smoother. All checking lives in the
// tssc_checker instance; this module only makes beats, drives the sink's
// ready, writes registers between phases, and prints the final result.
module tb_tick_sensor_smoother_click_detect;
    import tssc_pkg::*;

    localparam int LATENCY = 25;
    localparam int CYCLE_LIMIT = 1000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [11:0] sample_ch0 = '0, sample_ch1 = '0, sample_ch2 = '0, sample_ch3 = '0;
    logic [11:0] sample_ch4 = '0, sample_ch5 = '0, sample_ch6 = '0, sample_ch7 = '0;
    logic [15:0] speed_period = '0;
    logic speed_pulse = 1'b0;
    logic switch_level = 1'b1;
    logic [3:0] frames_done = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [11:0] smooth_ch0, smooth_ch1, smooth_ch2, smooth_ch3;
    logic [11:0] smooth_ch4, smooth_ch5, smooth_ch6, smooth_ch7;
    logic [19:0] speed_value;
    logic [10:0] frames_per_second;
    logic [1:0] click_event;

    int error_count;
    int pending_count;
    int cycle_count = 0;
    // The sink process reads this to start one long hold-off on its own.
    logic sink_hold_req = 1'b0;

    always #2 clk = ~clk;

    tick_sensor_smoother_click_detect u_dut (.*);
    tssc_checker u_checker (.*);

    // Watchdog on a free-running cycle count.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_tick_sensor_smoother_click_detect: done, errors");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one, often none at all.
    function automatic int idle_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return 0;
        if (pick < 93)
            return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    // Result side: random back-pressure, plus one long hold when asked.
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            if (sink_hold_req)
            begin
                out_ready <= 1'b0;
                repeat (600) @(posedge clk);
                sink_hold_req = 1'b0;
            end
            else
            begin
                gap = idle_gap();
                if (gap > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    // Write enable drops for one cycle after each write.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Every tick gives a result, so an empty queue means the block is idle.
    // The first wait lets the checker count the last accepted beat.
    task automatic drain();
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    // Sends one beat; valid stays high across back-to-back beats and only
    // drops when a gap follows.
    task automatic send_tick(input logic [7:0][11:0] s, input logic [15:0] period,
                             input logic pulse, input logic sw, input logic [3:0] frames,
                             input bit with_gaps);
        int gap;
        gap = with_gaps ? idle_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        {sample_ch7, sample_ch6, sample_ch5, sample_ch4,
         sample_ch3, sample_ch2, sample_ch1, sample_ch0} <= s;
        speed_period <= period;
        speed_pulse <= pulse;
        switch_level <= sw;
        frames_done <= frames;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_random(input int count, input bit short_press);
        logic [7:0][11:0] s;
        logic [15:0] period;
        int press_left;
        logic sw;
        press_left = 0;
        for (int n = 0; n < count; n++)
        begin
            for (int i = 0; i < 8; i++)
                s[i] = ($urandom_range(0, 9) == 0) ?
                       (($urandom_range(0, 1) == 1) ? 12'hFFF : 12'h000) : 12'($urandom);
            case ($urandom_range(0, 5))
                0: period = 16'd0;
                1: period = 16'($urandom_range(1, 20));
                2: period = 16'hFFFF;
                default: period = 16'($urandom);
            endcase
            // Presses are held for runs of ticks so the hold count passes
            // the single and long thresholds and saturates.
            if (press_left == 0 && $urandom_range(0, 9) == 0)
                press_left = short_press ? $urandom_range(1, 20) : $urandom_range(1, 140);
            sw = 1'b1;
            if (press_left > 0)
            begin
                sw = 1'b0;
                press_left--;
            end
            else if ($urandom_range(0, 19) == 0)
                sw = 1'b0;
            send_tick(s, period, ($urandom_range(0, 29) != 0) ? 1'b0 : 1'b1, sw,
                      4'($urandom), 1'b1);
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin
        logic [7:0][11:0] ones, zeros;
        ones = {8{12'hFFF}};
        zeros = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: full-scale and zero samples, zero and extreme periods,
        // pulses, a press through the single threshold, max frames.
        send_tick(ones, 16'd0, 1'b1, 1'b1, 4'hF, 1'b0);
        send_tick(ones, 16'd1, 1'b1, 1'b1, 4'hF, 1'b0);
        send_tick(zeros, 16'hFFFF, 1'b1, 1'b1, 4'h0, 1'b0);
        send_tick(ones, 16'd7, 1'b0, 1'b1, 4'h8, 1'b0);
        for (int n = 0; n < 12; n++)
            send_tick(12'hA5A ^ ones, 16'd3, 1'b0, 1'b0, 4'h1, 1'b0);
        send_tick(zeros, 16'd2, 1'b1, 1'b1, 4'h7, 1'b0);
        in_valid <= 1'b0;
        drain();

        // Fast timeout and thresholds at zero, heavy weights everywhere but channel 5.
        write_reg(REG_ALPHA_SHARED, 20'hFFFF);
        write_reg(REG_ALPHA_CH5, 20'h0);
        write_reg(REG_ALPHA_CH7, 20'hFFFF);
        write_reg(REG_ALPHA_SPEED, 20'hFFFF);
        write_reg(REG_SPEED_NUM, 20'hFFFFF);
        write_reg(REG_SPEED_TIMEOUT, 20'd0);
        write_reg(REG_CLICK_SHORT, 20'd0);
        write_reg(REG_CLICK_LONG, 20'd0);
        send_random(300, 1'b1);
        drain();

        // Thresholds at and above saturation, longest timeout.
        write_reg(REG_ALPHA_SHARED, 20'h0);
        write_reg(REG_ALPHA_CH5, 20'hFFFF);
        write_reg(REG_ALPHA_SPEED, 20'h1);
        write_reg(REG_SPEED_NUM, 20'd0);
        write_reg(REG_SPEED_TIMEOUT, 20'd127);
        write_reg(REG_CLICK_SHORT, 20'd100);
        write_reg(REG_CLICK_LONG, 20'd127);
        send_random(300, 1'b0);
        drain();

        // Random mid-range settings.
        write_reg(REG_ALPHA_SHARED, 20'($urandom));
        write_reg(REG_ALPHA_CH5, 20'($urandom));
        write_reg(REG_ALPHA_CH7, 20'($urandom));
        write_reg(REG_ALPHA_SPEED, 20'($urandom));
        write_reg(REG_SPEED_NUM, 20'($urandom));
        write_reg(REG_SPEED_TIMEOUT, 20'($urandom_range(1, 20)));
        write_reg(REG_CLICK_SHORT, 20'($urandom_range(1, 30)));
        write_reg(REG_CLICK_LONG, 20'($urandom_range(5, 60)));
        // The sink holds off for a long stretch while beats keep coming.
        sink_hold_req = 1'b1;
        send_random(400, 1'b0);
        drain();

        // Back to the power-up settings for the rest.
        write_reg(REG_ALPHA_SHARED, 20'd32768);
        write_reg(REG_ALPHA_CH5, 20'd655);
        write_reg(REG_ALPHA_CH7, 20'd7);
        write_reg(REG_ALPHA_SPEED, 20'd655);
        write_reg(REG_SPEED_NUM, 20'd704372);
        write_reg(REG_SPEED_TIMEOUT, 20'd100);
        write_reg(REG_CLICK_SHORT, 20'd10);
        write_reg(REG_CLICK_LONG, 20'd50);
        send_random(580, 1'b0);

        // Wait for the last results, then a latency's worth of quiet.
        drain();
        if (error_count == 0)
            $display("tb_tick_sensor_smoother_click_detect: done, clean");
        else
            $display("tb_tick_sensor_smoother_click_detect: done, errors");
        $finish;
    end
endmodule
